/* design/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg: shared definitions for the sorted priority queue
// Capacity, field widths, command and status codes, and the control bundle
// that the queue controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Table size and derived widths.
    localparam int CAPACITY    = 128;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int FOUND_W     = 7;
    localparam int COUNT_OUT_W = 8;

    // Command codes carried on the input tuser.
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_SEARCH  = 2'd2;
    localparam logic [1:0] CMD_CHANGE  = 2'd3;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    // Per-cell operation codes.
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    // Control broadcast from the controller to all cells.
    typedef struct packed {
        logic [1:0]       op;
        word_t            ins_data;
        word_t            ins_prio;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] pos;
        logic             load_match;
        logic             shift_match;
    } sps_ctrl_t;

endpackage

/* design/sps_cell.sv */
// ----------------------------------------------------------------------------
// sps_cell: one storage cell of the sorted priority queue
// Holds one entry and a match flag. On insert it keeps its entry, takes the
// new entry or takes its left neighbor's entry; on removal a cell at or after the
// removal position takes its right neighbor's entry. The match flags form a shift line toward the front.
// ----------------------------------------------------------------------------
module sps_cell (
    input  logic              aclk,
    input  logic [sps_pkg::CNT_W-1:0] cell_index,
    input  sps_pkg::sps_ctrl_t ctrl,
    input  logic              left_ge,
    input  sps_pkg::word_t    left_data,
    input  sps_pkg::word_t    left_prio,
    input  sps_pkg::word_t    right_data,
    input  sps_pkg::word_t    right_prio,
    input  logic              right_match,
    output logic              cell_ge,
    output sps_pkg::word_t    cell_data,
    output sps_pkg::word_t    cell_prio,
    output logic              cell_match
);
    import sps_pkg::*;

    word_t data_reg;
    word_t data_next;
    word_t prio_reg;
    word_t prio_next;
    logic  match_reg;
    logic  match_next;
    logic  occupied;
    logic  at_or_after_pos;

    // The cell holds a live entry when its index is below the count.
    assign occupied        = cell_index < ctrl.count;
    assign at_or_after_pos = cell_index >= CNT_W'(ctrl.pos);

    // Entries of greater or equal priority stay ahead of a new entry.
    assign cell_ge = occupied && (prio_reg >= ctrl.ins_prio);

    // Entry update.
    always_comb begin
        data_next = data_reg;
        prio_next = prio_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (!cell_ge) begin
                    if (left_ge) begin
                        data_next = ctrl.ins_data;
                        prio_next = ctrl.ins_prio;
                    end else begin
                        data_next = left_data;
                        prio_next = left_prio;
                    end
                end
            end
            CELL_REMOVE: begin
                if (at_or_after_pos) begin
                    data_next = right_data;
                    prio_next = right_prio;
                end
            end
            default: begin
                data_next = data_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    // Match flag: loaded from a data compare, then shifted toward the front.
    always_comb begin
        match_next = match_reg;
        if (ctrl.load_match) begin
            match_next = occupied && (data_reg == ctrl.ins_data);
        end else if (ctrl.shift_match) begin
            match_next = right_match;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        prio_reg  <= prio_next;
        match_reg <= match_next;
    end

    assign cell_data  = data_reg;
    assign cell_prio  = prio_reg;
    assign cell_match = match_reg;

endmodule

/* design/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue kept as a sorted row of cells
// Entries are held front to back from highest to lowest priority. Enqueue
// places an entry behind all entries of greater or equal priority; dequeue
// takes the front; search and change priority locate the first matching data.
//
//  Channel | Direction | Ports            | Contents (lowest bit first)
//  --------+-----------+------------------+---------------------------------
//  s_      | input     | tvalid/tready    | tuser: command; tdata: data, prio
//  m_      | output    | tvalid/tready    | tuser: status; tdata: results
//
// Enqueue and dequeue pass from acceptance through the execute step to the report
// step, which loads the result. Search and change priority first scan for the match
// position (or run to the entry count when nothing matches), and change priority adds
// a re-insert step; the match flags shift one cell per cycle toward the front.
// aresetn clears the count and the control; the cells need no clearing.
// A result waiting on m_ does not block acceptance of the next transaction;
// only the final result load waits for the output register to free up.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // item_data[31:0], item_priority[63:32]
    input  logic [1:0]   s_tuser,   // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // removed_data[31:0], removed_priority[63:32],
                                    // found_position[70:64], head_data[102:71],
                                    // head_priority[134:103], entry_count[142:135],
                                    // is_empty[143], is_full[144], zero pad
    output logic [1:0]   m_tuser    // status[1:0]
);
    import sps_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    logic [2:0]       state_reg,  state_next;
    logic [1:0]       cmd_reg,    cmd_next;
    word_t            data_reg,   data_next;
    word_t            prio_reg,   prio_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] scan_reg,   scan_next;
    logic [IDX_W-1:0] pos_reg,    pos_next;
    logic             found_reg,  found_next;
    logic [1:0]       status_reg, status_next;
    word_t            rem_data_reg, rem_data_next;
    word_t            rem_prio_reg, rem_prio_next;

    logic             m_valid_reg, m_valid_next;
    logic [151:0]     m_data_reg,  m_data_next;
    logic [1:0]       m_user_reg,  m_user_next;

    sps_ctrl_t        cell_ctrl;
    logic             chain_ge    [0:CAPACITY];
    word_t            chain_data  [0:CAPACITY+1];
    word_t            chain_prio  [0:CAPACITY+1];
    logic             chain_match [0:CAPACITY];

    logic             s_accept;
    logic             out_free;
    logic             queue_empty;
    logic             queue_full;
    word_t            head_data;
    word_t            head_prio;
    logic [IDX_W+FOUND_W-1:0]     pos_wide;
    logic [FOUND_W-1:0]           found_pos;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
    logic [COUNT_OUT_W-1:0]       count_out;

    assign s_tready    = state_reg == ST_IDLE;
    assign s_accept    = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign queue_empty = count_reg == '0;
    assign queue_full  = count_reg == CNT_W'(CAPACITY);

    // Ends of the neighbor chains.
    assign chain_ge[0]                = 1'b1;
    assign chain_data[0]              = '0;
    assign chain_prio[0]              = '0;
    assign chain_data[CAPACITY+1]     = '0;
    assign chain_prio[CAPACITY+1]     = '0;
    assign chain_match[CAPACITY]      = 1'b0;

    // Row of storage cells; cell g drives slot g+1 of the data chains.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sps_cell u_cell (
            .aclk        (aclk),
            .cell_index  (CNT_W'(g)),
            .ctrl        (cell_ctrl),
            .left_ge     (chain_ge[g]),
            .left_data   (chain_data[g]),
            .left_prio   (chain_prio[g]),
            .right_data  (chain_data[g+2]),
            .right_prio  (chain_prio[g+2]),
            .right_match (chain_match[g+1]),
            .cell_ge     (chain_ge[g+1]),
            .cell_data   (chain_data[g+1]),
            .cell_prio   (chain_prio[g+1]),
            .cell_match  (chain_match[g])
        );
    end

    // Front entry as it stands now.
    assign head_data = queue_empty ? '1 : chain_data[1];
    assign head_prio = queue_empty ? '1 : chain_prio[1];

    // Output fields resized to their port widths.
    assign pos_wide   = {{FOUND_W{1'b0}}, pos_reg};
    assign found_pos  = (cmd_reg == CMD_SEARCH && found_reg) ? pos_wide[FOUND_W-1:0] : '0;
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign count_out  = count_wide[COUNT_OUT_W-1:0];

    // Sequencer: accept, scan for a data match, update the cells, report.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        data_next     = data_reg;
        prio_next     = prio_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        rem_data_next = rem_data_reg;
        rem_prio_next = rem_prio_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        cell_ctrl.op          = CELL_HOLD;
        cell_ctrl.ins_data    = (state_reg == ST_IDLE) ? word_t'(s_tdata[31:0]) : data_reg;
        cell_ctrl.ins_prio    = prio_reg;
        cell_ctrl.count       = count_reg;
        cell_ctrl.pos         = pos_reg;
        cell_ctrl.load_match  = 1'b0;
        cell_ctrl.shift_match = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next             = s_tuser;
                    data_next            = word_t'(s_tdata[31:0]);
                    prio_next            = word_t'(s_tdata[63:32]);
                    scan_next            = '0;
                    found_next           = 1'b0;
                    cell_ctrl.load_match = 1'b1;
                    if (s_tuser == CMD_ENQUEUE || s_tuser == CMD_DEQUEUE) begin
                        state_next = ST_EXEC;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_reg == count_reg) begin
                    found_next = 1'b0;
                    state_next = ST_EXEC;
                end else if (chain_match[0]) begin
                    found_next = 1'b1;
                    pos_next   = scan_reg[IDX_W-1:0];
                    state_next = ST_EXEC;
                end else begin
                    cell_ctrl.shift_match = 1'b1;
                    scan_next             = scan_reg + CNT_W'(1);
                end
            end
            ST_EXEC: begin
                status_next   = STATUS_OK;
                rem_data_next = '0;
                rem_prio_next = '0;
                state_next    = ST_REPORT;
                unique case (cmd_reg)
                    CMD_ENQUEUE: begin
                        if (queue_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            cell_ctrl.op = CELL_INSERT;
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_DEQUEUE: begin
                        if (queue_empty) begin
                            status_next   = STATUS_EMPTY;
                            rem_data_next = '1;
                            rem_prio_next = '1;
                        end else begin
                            rem_data_next = chain_data[1];
                            rem_prio_next = chain_prio[1];
                            cell_ctrl.op  = CELL_REMOVE;
                            cell_ctrl.pos = '0;
                            count_next    = count_reg - CNT_W'(1);
                        end
                    end
                    CMD_SEARCH: begin
                        if (!found_reg) begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                    CMD_CHANGE: begin
                        if (found_reg) begin
                            cell_ctrl.op = CELL_REMOVE;
                            count_next   = count_reg - CNT_W'(1);
                            state_next   = ST_INSERT;
                        end else begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                    default: begin
                        status_next = STATUS_OK;
                    end
                endcase
            end
            ST_INSERT: begin
                // One entry was just removed, so the insert always fits.
                cell_ctrl.op = CELL_INSERT;
                count_next   = count_reg + CNT_W'(1);
                state_next   = ST_REPORT;
            end
            ST_REPORT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {7'b0, queue_full, queue_empty, count_out,
                                    head_prio, head_data, found_pos,
                                    rem_prio_reg, rem_data_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        data_reg     <= data_next;
        prio_reg     <= prio_next;
        scan_reg     <= scan_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        rem_data_reg <= rem_data_next;
        rem_prio_reg <= rem_prio_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A new result appears only from the report step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_REPORT))
        else $error("result loaded outside the report step");

    // The re-insert of a change follows its removal and always has room.
    a_reinsert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INSERT |-> $past(state_reg == ST_EXEC) && !queue_full)
        else $error("re-insert without a preceding removal");

    // The two front entries stay in priority order.
    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && count_reg >= CNT_W'(2)) |-> chain_prio[1] >= chain_prio[2])
        else $error("front entries out of priority order");

    // A scan never runs past the stored entries.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_reg <= count_reg)
        else $error("match scan beyond the stored entries");

endmodule
